/* sv/vit_pkg.sv */
// shared types, constants and helpers of the virtual interval timer port block
package vit_pkg;

    localparam int NUM_COUNTERS = 3;
    localparam int CNT_IDX_W    = $clog2(NUM_COUNTERS);

    localparam int PORT_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int TICK_W   = 32;
    localparam int RELOAD_W = 16;
    localparam int PERIOD_W = RELOAD_W + 1;
    localparam int IRQ_W    = 17;
    localparam int DIV_STEPS = TICK_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [PORT_W-1:0] PORT_CNT0_LO = 16'h0071;
    localparam logic [PORT_W-1:0] PORT_CNT1_LO = 16'h0073;
    localparam logic [PORT_W-1:0] PORT_CNT2_LO = 16'h0075;
    localparam logic [PORT_W-1:0] PORT_CMD_LO  = 16'h0077;
    localparam logic [PORT_W-1:0] PORT_CNT0_HI = 16'h3FD9;
    localparam logic [PORT_W-1:0] PORT_CNT1_HI = 16'h3FDB;
    localparam logic [PORT_W-1:0] PORT_CNT2_HI = 16'h3FDD;
    localparam logic [PORT_W-1:0] PORT_CMD_HI  = 16'h3FDF;

    localparam logic [RELOAD_W-1:0] RELOAD_RESET = 16'h4E00;
    localparam logic [RELOAD_W-1:0] BASE_RESET   = 16'd19968;
    localparam logic [PERIOD_W-1:0] PERIOD_FULL  = 17'h10000;
    localparam logic [BYTE_W-1:0]   CMD_READ_DATA = 8'hFF;

    // read/write byte modes
    localparam logic [1:0] BM_NONE = 2'd0;
    localparam logic [1:0] BM_LSB  = 2'd1;
    localparam logic [1:0] BM_MSB  = 2'd2;
    localparam logic [1:0] BM_BOTH = 2'd3;

    localparam logic [1:0] SC_READBACK = 2'd3;
    localparam logic [1:0] RL_LATCH    = 2'd0;
    localparam logic [2:0] MODE_RESET  = 3'd3;

    // kinds of port access
    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_CMDRD = 3'd1;
    localparam logic [2:0] KIND_CMDWR = 3'd2;
    localparam logic [2:0] KIND_DWR   = 3'd3;
    localparam logic [2:0] KIND_DRD   = 3'd4;

    typedef struct packed {
        logic                op;
        logic [PORT_W-1:0]   port;
        logic [BYTE_W-1:0]   write_data;
        logic [TICK_W-1:0]   tick_now;
    } t_in_item;

    typedef struct packed {
        logic                handled;
        logic [BYTE_W-1:0]   read_data;
        logic                pass_through;
        logic [IRQ_W-1:0]    irq_divisor;
    } t_out_item;

    typedef logic [RELOAD_W-1:0] t_cfg_word;

    typedef struct packed {
        logic                start;
        logic [TICK_W-1:0]   dividend;
        logic [PERIOD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [TICK_W-1:0]   quotient;
        logic [PERIOD_W-1:0] remainder;
    } t_div_rsp;

    // a reload of zero counts the full 16-bit range
    function automatic logic [PERIOD_W-1:0] period_of(input logic [RELOAD_W-1:0] r);
        return (r == '0) ? PERIOD_FULL : {1'b0, r};
    endfunction

    function automatic logic [RELOAD_W-1:0] base_of(input logic [RELOAD_W-1:0] b);
        return (b == '0) ? RELOAD_W'(1) : b;
    endfunction

endpackage

/* sv/vit_chan_if.sv */
// valid/ready channel carrying one payload word
interface vit_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/vit_div.sv */
// shared restoring divider, one quotient bit per cycle
module vit_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vit_pkg::t_div_req i_req,
    output vit_pkg::t_div_rsp o_rsp
);
    logic                              r_busy;
    logic                              r_done;
    logic [vit_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [vit_pkg::TICK_W-1:0]        r_quo;
    logic [vit_pkg::PERIOD_W-1:0]      r_rem;
    logic [vit_pkg::PERIOD_W-1:0]      r_dvs;

    logic [vit_pkg::PERIOD_W:0] shifted;
    logic [vit_pkg::PERIOD_W:0] diff;
    logic                       ge;

    assign shifted = {r_rem, r_quo[vit_pkg::TICK_W-1]};
    assign ge      = shifted >= {1'b0, r_dvs};
    assign diff    = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= vit_pkg::DIV_CNT_W'(vit_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == vit_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[vit_pkg::TICK_W-2:0], ge};
            // when not ge the shifted value is below the divisor, so it fits
            r_rem <= ge ? diff[vit_pkg::PERIOD_W-1:0] : shifted[vit_pkg::PERIOD_W-1:0];
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

/* sv/virtual_interval_timer_ports.sv */
// top level of the virtual interval timer port block
// One port access is taken per transaction and gives one result. An access that needs the
// current count estimate (a latch command, or a data read of a counter that is not latched)
// runs the shared 32-step restoring divider twice, once for the count modulo the reload and
// once for the counter-0 interrupt divisor; every other access runs it only for the divisor.
// The next access is taken once the current one is finished, even while its result still
// waits on the output register; an access only stalls in its last step while the previous
// result has not been taken.
module virtual_interval_timer_ports (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vit_chan_if.sink    i_in,
    vit_chan_if.source  o_out,
    vit_chan_if.sink    i_cfg
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_ESTGO = 4'd3;
    localparam logic [3:0] S_ESTW  = 4'd4;
    localparam logic [3:0] S_APPLY = 4'd5;
    localparam logic [3:0] S_QGO   = 4'd6;
    localparam logic [3:0] S_QW    = 4'd7;
    localparam logic [3:0] S_PUSH  = 4'd8;

    localparam int N  = vit_pkg::NUM_COUNTERS;
    localparam int KW = vit_pkg::CNT_IDX_W;
    localparam int RW = vit_pkg::RELOAD_W;
    localparam int TW = vit_pkg::TICK_W;

    logic [3:0]                       r_state;
    vit_pkg::t_in_item                r_item;
    logic [RW-1:0]                    r_base;

    logic [2:0]                       r_count_mode      [N];
    logic [1:0]                       r_byte_mode       [N];
    logic [RW-1:0]                    r_reload          [N];
    logic                             r_write_high_next [N];
    logic                             r_read_high_next  [N];
    logic                             r_is_latched      [N];
    logic [RW-1:0]                    r_latched_count   [N];
    logic [TW-1:0]                    r_reload_tick     [N];

    logic [2:0]                       r_kind;
    logic [KW-1:0]                    r_k;
    logic [TW-1:0]                    r_elapsed;
    logic [TW-1:0]                    r_prod;
    logic [RW-1:0]                    r_est;
    logic                             r_handled;
    logic [vit_pkg::BYTE_W-1:0]       r_rd;
    logic                             r_pass;
    logic [vit_pkg::IRQ_W-1:0]        r_div;
    logic                             r_ov;
    vit_pkg::t_out_item               r_out;

    vit_pkg::t_div_req                div_req;
    vit_pkg::t_div_rsp                div_rsp;

    // decode of the held access
    logic                             is_cmd;
    logic                             is_data;
    logic [KW-1:0]                    dk;
    logic [1:0]                       sc;
    logic [1:0]                       rl;
    logic [2:0]                       kind;
    logic [KW-1:0]                    kk;
    logic                             need_est;
    logic [TW+RW-1:0]                 prod_full;
    logic [vit_pkg::PERIOD_W-1:0]     period_k;
    logic [RW-1:0]                    rd_value;
    logic                             out_free;

    assign sc = r_item.write_data[7:6];
    assign rl = r_item.write_data[5:4];

    always_comb begin
        is_cmd  = (r_item.port == vit_pkg::PORT_CMD_LO) || (r_item.port == vit_pkg::PORT_CMD_HI);
        is_data = 1'b1;
        dk      = '0;
        unique case (r_item.port)
            vit_pkg::PORT_CNT0_LO, vit_pkg::PORT_CNT0_HI: dk = KW'(0);
            vit_pkg::PORT_CNT1_LO, vit_pkg::PORT_CNT1_HI: dk = KW'(1);
            vit_pkg::PORT_CNT2_LO, vit_pkg::PORT_CNT2_HI: dk = KW'(2);
            default: is_data = 1'b0;
        endcase

        kind = vit_pkg::KIND_NONE;
        if (is_cmd) begin
            kind = r_item.op ? vit_pkg::KIND_CMDWR : vit_pkg::KIND_CMDRD;
        end else if (is_data) begin
            kind = r_item.op ? vit_pkg::KIND_DWR : vit_pkg::KIND_DRD;
        end

        // counter index, kept in range for the read-back select
        kk = '0;
        if (is_cmd && sc != vit_pkg::SC_READBACK) begin
            kk = sc[KW-1:0];
        end else if (is_data) begin
            kk = dk;
        end

        need_est = ((kind == vit_pkg::KIND_CMDWR) && (sc != vit_pkg::SC_READBACK) &&
                    (rl == vit_pkg::RL_LATCH)) ||
                   ((kind == vit_pkg::KIND_DRD) && !r_is_latched[kk]);
    end

    assign prod_full = r_elapsed * vit_pkg::base_of(r_base);
    assign period_k  = vit_pkg::period_of(r_reload[r_k]);
    assign rd_value  = r_is_latched[r_k] ? r_latched_count[r_k] : r_est;
    assign out_free  = !r_ov || o_out.ready;

    always_comb begin
        div_req.start    = (r_state == S_ESTGO) || (r_state == S_QGO);
        div_req.dividend = r_prod;
        div_req.divisor  = period_k;
        if (r_state == S_QGO) begin
            div_req.dividend = TW'(vit_pkg::period_of(r_reload[0]));
            div_req.divisor  = {1'b0, vit_pkg::base_of(r_base)};
        end
    end

    vit_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_base  <= vit_pkg::BASE_RESET;
        end else begin
            if (i_cfg.valid) begin
                r_base <= i_cfg.data;
            end
            if (r_state == S_PUSH && out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC:   r_state <= need_est ? S_MUL : S_APPLY;
                S_MUL:   r_state <= S_ESTGO;
                S_ESTGO: r_state <= S_ESTW;
                S_ESTW: begin
                    if (div_rsp.done) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: r_state <= S_QGO;
                S_QGO:   r_state <= S_QW;
                S_QW: begin
                    if (div_rsp.done) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // working registers of the current access
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_item <= i_in.data;
        end
        if (r_state == S_DEC) begin
            r_kind    <= kind;
            r_k       <= kk;
            r_elapsed <= r_item.tick_now - r_reload_tick[kk];
        end
        if (r_state == S_MUL) begin
            r_prod <= prod_full[TW-1:0];
        end
        if (r_state == S_ESTW && div_rsp.done) begin
            r_est <= RW'(period_k - div_rsp.remainder);
        end
        if (r_state == S_QW && div_rsp.done) begin
            r_div <= (div_rsp.quotient == '0) ? vit_pkg::IRQ_W'(1)
                                              : div_rsp.quotient[vit_pkg::IRQ_W-1:0];
        end
        if (r_state == S_PUSH && out_free) begin
            r_out.handled      <= r_handled;
            r_out.read_data    <= r_rd;
            r_out.pass_through <= r_pass;
            r_out.irq_divisor  <= r_div;
        end
    end

    // counter state, updated once per access
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_count_mode[i]      <= vit_pkg::MODE_RESET;
                r_byte_mode[i]       <= vit_pkg::BM_BOTH;
                r_reload[i]          <= vit_pkg::RELOAD_RESET;
                r_write_high_next[i] <= 1'b0;
                r_read_high_next[i]  <= 1'b0;
                r_is_latched[i]      <= 1'b0;
                r_latched_count[i]   <= '0;
                r_reload_tick[i]     <= '0;
            end
        end else if (r_state == S_APPLY) begin
            unique case (r_kind)
                vit_pkg::KIND_CMDWR: begin
                    if (sc != vit_pkg::SC_READBACK) begin
                        if (rl == vit_pkg::RL_LATCH) begin
                            r_is_latched[r_k]     <= 1'b1;
                            r_latched_count[r_k]  <= r_est;
                            r_read_high_next[r_k] <= 1'b0;
                        end else begin
                            r_byte_mode[r_k]       <= rl;
                            r_count_mode[r_k]      <= r_item.write_data[3:1];
                            r_write_high_next[r_k] <= 1'b0;
                            r_read_high_next[r_k]  <= 1'b0;
                            r_is_latched[r_k]      <= 1'b0;
                        end
                    end
                end
                vit_pkg::KIND_DWR: begin
                    unique case (r_byte_mode[r_k])
                        vit_pkg::BM_LSB: begin
                            r_reload[r_k][7:0] <= r_item.write_data;
                            r_reload_tick[r_k] <= r_item.tick_now;
                        end
                        vit_pkg::BM_MSB: begin
                            r_reload[r_k][15:8] <= r_item.write_data;
                            r_reload_tick[r_k]  <= r_item.tick_now;
                        end
                        vit_pkg::BM_BOTH: begin
                            if (!r_write_high_next[r_k]) begin
                                r_reload[r_k][7:0]     <= r_item.write_data;
                                r_write_high_next[r_k] <= 1'b1;
                            end else begin
                                r_reload[r_k][15:8]    <= r_item.write_data;
                                r_write_high_next[r_k] <= 1'b0;
                                r_reload_tick[r_k]     <= r_item.tick_now;
                            end
                        end
                        default: ;
                    endcase
                end
                vit_pkg::KIND_DRD: begin
                    unique case (r_byte_mode[r_k])
                        vit_pkg::BM_LSB, vit_pkg::BM_MSB: r_is_latched[r_k] <= 1'b0;
                        vit_pkg::BM_BOTH: begin
                            if (!r_read_high_next[r_k]) begin
                                r_read_high_next[r_k] <= 1'b1;
                            end else begin
                                r_read_high_next[r_k] <= 1'b0;
                                r_is_latched[r_k]     <= 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // result fields of the access
    always_ff @(posedge i_clk) begin
        if (r_state == S_APPLY) begin
            r_handled <= (r_kind != vit_pkg::KIND_NONE);
            r_rd      <= '0;
            r_pass    <= 1'b0;
            unique case (r_kind)
                vit_pkg::KIND_CMDRD: r_rd <= vit_pkg::CMD_READ_DATA;
                vit_pkg::KIND_CMDWR: r_pass <= (sc == 2'd1);
                vit_pkg::KIND_DWR:   r_pass <= (r_k == KW'(1));
                vit_pkg::KIND_DRD: begin
                    unique case (r_byte_mode[r_k])
                        vit_pkg::BM_LSB:  r_rd <= rd_value[7:0];
                        vit_pkg::BM_MSB:  r_rd <= rd_value[15:8];
                        vit_pkg::BM_BOTH: r_rd <= r_read_high_next[r_k] ? rd_value[15:8]
                                                                        : rd_value[7:0];
                        default:          r_rd <= '0;
                    endcase
                end
                default: ;
            endcase
        end
    end

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_DEC))
        else $error("accepted access did not enter decode");

    a_div_start_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> (r_state == S_ESTGO || r_state == S_QGO))
        else $error("divider started outside a launch state");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_ESTW || r_state == S_QW))
        else $error("divider finished while nobody waits");

    a_irq_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.irq_divisor != '0))
        else $error("interrupt divisor is zero");

endmodule

/* dv/testbench.sv */
// self-checking testbench for the virtual interval timer port block
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int PHASE_ITEMS  = 360;
    localparam int NUM_PHASES   = 5;
    localparam int SETTLE_CYC   = 90;
    localparam int CNT_PASS     = 1;   // counter whose writes also reach the real timer

    localparam logic OP_RD = 1'b0;
    localparam logic OP_WR = 1'b1;

    typedef struct packed {
        logic                       op;
        logic [vit_pkg::PORT_W-1:0] port;
        logic [vit_pkg::BYTE_W-1:0] wdata;
        logic [vit_pkg::TICK_W-1:0] tick;
        logic                       typed;
        vit_pkg::t_out_item         want;
    } t_script_row;

    localparam vit_pkg::t_out_item NO_EXP = '0;
    localparam int NUM_ROWS = 26;

    localparam t_script_row SCRIPT [NUM_ROWS] = '{
        '{OP_RD, vit_pkg::PORT_CMD_LO, 8'h00, 32'h0000_0000, 1'b1, '{1'b1, 8'hFF, 1'b0, 17'd1}},
        '{OP_RD, 16'h0000, 8'h00, 32'h0000_0000, 1'b1, '{1'b0, 8'h00, 1'b0, 17'd1}},
        '{OP_WR, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 8'h00, 1'b0, 17'd1}},
        '{OP_RD, vit_pkg::PORT_CNT0_LO, 8'h00, 32'h0000_0000, 1'b1, '{1'b1, 8'h00, 1'b0, 17'd1}},
        '{OP_RD, vit_pkg::PORT_CNT0_HI, 8'h00, 32'h0000_0000, 1'b1, '{1'b1, 8'h4E, 1'b0, 17'd1}},
        '{OP_WR, vit_pkg::PORT_CMD_HI, 8'hFE, 32'h0000_0000, 1'b1, '{1'b1, 8'h00, 1'b0, 17'd1}},
        '{OP_WR, vit_pkg::PORT_CMD_LO, 8'h30, 32'h0000_0000, 1'b1, '{1'b1, 8'h00, 1'b0, 17'd1}},
        '{OP_WR, vit_pkg::PORT_CNT0_LO, 8'hFF, 32'd100,       1'b0, NO_EXP},
        '{OP_WR, vit_pkg::PORT_CNT0_HI, 8'hFF, 32'd200,       1'b0, NO_EXP},
        '{OP_WR, vit_pkg::PORT_CMD_LO,  8'h00, 32'hFFFF_FFFF, 1'b0, NO_EXP},
        '{OP_RD, vit_pkg::PORT_CNT0_LO, 8'h00, 32'd300,       1'b0, NO_EXP},
        '{OP_RD, vit_pkg::PORT_CNT0_LO, 8'h00, 32'd400,       1'b0, NO_EXP},
        '{OP_WR, vit_pkg::PORT_CMD_LO,  8'h76, 32'd5,         1'b0, NO_EXP},
        '{OP_WR, vit_pkg::PORT_CNT1_LO, 8'h00, 32'd10,        1'b0, NO_EXP},
        '{OP_WR, vit_pkg::PORT_CNT1_HI, 8'h00, 32'd20,        1'b0, NO_EXP},
        '{OP_RD, vit_pkg::PORT_CNT1_HI, 8'h00, 32'h8000_0000, 1'b0, NO_EXP},
        '{OP_WR, vit_pkg::PORT_CMD_HI,  8'h50, 32'd30,        1'b0, NO_EXP},
        '{OP_WR, vit_pkg::PORT_CNT1_HI, 8'hAA, 32'd7,         1'b0, NO_EXP},
        '{OP_RD, vit_pkg::PORT_CNT1_LO, 8'h00, 32'd1234,      1'b0, NO_EXP},
        '{OP_WR, vit_pkg::PORT_CMD_LO,  8'hAE, 32'd40,        1'b0, NO_EXP},
        '{OP_WR, vit_pkg::PORT_CNT2_LO, 8'h00, 32'd1,         1'b0, NO_EXP},
        '{OP_RD, vit_pkg::PORT_CNT2_HI, 8'h00, 32'd2,         1'b0, NO_EXP},
        '{OP_WR, vit_pkg::PORT_CMD_LO,  8'h40, 32'hFFFF_0000, 1'b0, NO_EXP},
        '{OP_WR, vit_pkg::PORT_CMD_HI,  8'h3E, 32'd50,        1'b0, NO_EXP},
        '{OP_WR, vit_pkg::PORT_CNT0_LO, 8'h00, 32'd60,        1'b0, NO_EXP},
        '{OP_WR, vit_pkg::PORT_CNT0_HI, 8'h00, 32'd70,        1'b0, NO_EXP}
    };

    localparam logic [vit_pkg::PORT_W-1:0] TIMER_PORTS [8] = '{
        vit_pkg::PORT_CNT0_LO, vit_pkg::PORT_CNT1_LO, vit_pkg::PORT_CNT2_LO, vit_pkg::PORT_CMD_LO,
        vit_pkg::PORT_CNT0_HI, vit_pkg::PORT_CNT1_HI, vit_pkg::PORT_CNT2_HI, vit_pkg::PORT_CMD_HI
    };

    logic i_clk;
    logic i_rst_n;

    vit_chan_if #(.t_payload(vit_pkg::t_in_item))  in_ch  ();
    vit_chan_if #(.t_payload(vit_pkg::t_out_item)) out_ch ();
    vit_chan_if #(.t_payload(vit_pkg::t_cfg_word)) cfg_ch ();

    virtual_interval_timer_ports i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // shadow timer state
    logic [vit_pkg::RELOAD_W-1:0] base_cfg;
    logic [2:0]                   cnt_mode    [vit_pkg::NUM_COUNTERS];
    logic [1:0]                   rw_mode     [vit_pkg::NUM_COUNTERS];
    logic [vit_pkg::RELOAD_W-1:0] reload_val  [vit_pkg::NUM_COUNTERS];
    logic                         wr_msb_next [vit_pkg::NUM_COUNTERS];
    logic                         rd_msb_next [vit_pkg::NUM_COUNTERS];
    logic                         latch_flag  [vit_pkg::NUM_COUNTERS];
    logic [vit_pkg::RELOAD_W-1:0] latch_val   [vit_pkg::NUM_COUNTERS];
    logic [vit_pkg::TICK_W-1:0]   load_tick   [vit_pkg::NUM_COUNTERS];

    vit_pkg::t_out_item pending_results [$];

    int fail_count = 0;
    int n_sent     = 0;
    int n_checked  = 0;
    int n_settings = 0;
    int burst_left = 0;
    int cycle_count = 0;

    logic [15:0] stall_pat;
    logic [8:0]  stall_tick;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic logic [vit_pkg::RELOAD_W-1:0] count_estimate(
            input int k, input logic [vit_pkg::TICK_W-1:0] now);
        logic [vit_pkg::TICK_W-1:0] per;
        logic [vit_pkg::TICK_W-1:0] b;
        logic [vit_pkg::TICK_W-1:0] counts;
        logic [vit_pkg::TICK_W-1:0] left;
        per    = (reload_val[k] == '0) ? 32'h1_0000 : {16'd0, reload_val[k]};
        b      = (base_cfg == '0) ? 32'd1 : {16'd0, base_cfg};
        counts = (now - load_tick[k]) * b;
        left   = per - (counts % per);
        return left[vit_pkg::RELOAD_W-1:0];
    endfunction

    // applies one port access to the shadow state and returns its result
    function automatic vit_pkg::t_out_item predict_access(input vit_pkg::t_in_item it);
        vit_pkg::t_out_item           r;
        int                           k;
        int                           sc;
        logic [1:0]                   rl;
        logic [vit_pkg::RELOAD_W-1:0] v;
        logic [vit_pkg::PERIOD_W-1:0] per0;
        logic [vit_pkg::PERIOD_W-1:0] b;
        r = '0;
        case (it.port)
            vit_pkg::PORT_CNT0_LO, vit_pkg::PORT_CNT0_HI: k = 0;
            vit_pkg::PORT_CNT1_LO, vit_pkg::PORT_CNT1_HI: k = 1;
            vit_pkg::PORT_CNT2_LO, vit_pkg::PORT_CNT2_HI: k = 2;
            default:                                      k = -1;
        endcase
        if (it.port == vit_pkg::PORT_CMD_LO || it.port == vit_pkg::PORT_CMD_HI) begin
            r.handled = 1'b1;
            if (it.op == OP_RD) begin
                r.read_data = vit_pkg::CMD_READ_DATA;
            end else if (it.write_data[7:6] != vit_pkg::SC_READBACK) begin
                sc = int'(it.write_data[7:6]);
                rl = it.write_data[5:4];
                if (rl == vit_pkg::RL_LATCH) begin
                    latch_flag[sc]  = 1'b1;
                    latch_val[sc]   = count_estimate(sc, it.tick_now);
                    rd_msb_next[sc] = 1'b0;
                end else begin
                    rw_mode[sc]     = rl;
                    cnt_mode[sc]    = it.write_data[3:1];
                    wr_msb_next[sc] = 1'b0;
                    rd_msb_next[sc] = 1'b0;
                    latch_flag[sc]  = 1'b0;
                end
                if (sc == CNT_PASS) r.pass_through = 1'b1;
            end
        end else if (k >= 0) begin
            r.handled = 1'b1;
            if (it.op == OP_WR) begin
                case (rw_mode[k])
                    vit_pkg::BM_LSB: begin
                        reload_val[k] = {reload_val[k][15:8], it.write_data};
                        load_tick[k]  = it.tick_now;
                    end
                    vit_pkg::BM_MSB: begin
                        reload_val[k] = {it.write_data, reload_val[k][7:0]};
                        load_tick[k]  = it.tick_now;
                    end
                    vit_pkg::BM_BOTH: begin
                        if (!wr_msb_next[k]) begin
                            reload_val[k]  = {reload_val[k][15:8], it.write_data};
                            wr_msb_next[k] = 1'b1;
                        end else begin
                            reload_val[k]  = {it.write_data, reload_val[k][7:0]};
                            wr_msb_next[k] = 1'b0;
                            load_tick[k]   = it.tick_now;
                        end
                    end
                    default: ;
                endcase
                if (k == CNT_PASS) r.pass_through = 1'b1;
            end else begin
                v = latch_flag[k] ? latch_val[k] : count_estimate(k, it.tick_now);
                case (rw_mode[k])
                    vit_pkg::BM_LSB: begin
                        r.read_data   = v[7:0];
                        latch_flag[k] = 1'b0;
                    end
                    vit_pkg::BM_MSB: begin
                        r.read_data   = v[15:8];
                        latch_flag[k] = 1'b0;
                    end
                    vit_pkg::BM_BOTH: begin
                        if (!rd_msb_next[k]) begin
                            r.read_data    = v[7:0];
                            rd_msb_next[k] = 1'b1;
                        end else begin
                            r.read_data    = v[15:8];
                            rd_msb_next[k] = 1'b0;
                            latch_flag[k]  = 1'b0;
                        end
                    end
                    default: r.read_data = '0;
                endcase
            end
        end
        per0 = (reload_val[0] == '0) ? vit_pkg::PERIOD_FULL : {1'b0, reload_val[0]};
        b    = (base_cfg == '0) ? 17'd1 : {1'b0, base_cfg};
        r.irq_divisor = per0 / b;
        if (r.irq_divisor == '0) r.irq_divisor = 17'd1;
        return r;
    endfunction

    // bursts of back-to-back accesses separated by random gaps
    function automatic int next_gap();
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 10);
            return $urandom_range(1, 24);
        end
        burst_left--;
        return 0;
    endfunction

    task automatic send_access(input vit_pkg::t_in_item it, input logic typed,
                               input vit_pkg::t_out_item want);
        vit_pkg::t_out_item predicted;
        int                 gap;
        gap = next_gap();
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        predicted = predict_access(it);
        pending_results.push_back(typed ? want : predicted);
        n_sent++;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // sender holds off until every result is back and the block has gone quiet
    task automatic settle(input int extra);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_base(input vit_pkg::t_cfg_word value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        base_cfg = value;
        n_settings++;
    endtask

    // receiver stall pattern, reshuffled whenever the 9-bit stall tick wraps; all ones means no stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_pat    <= 16'hA5C3;
            stall_tick   <= '0;
        end else begin
            stall_tick <= stall_tick + 9'd1;
            if (stall_tick == '0) begin
                stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            end else begin
                stall_pat <= {stall_pat[14:0], stall_pat[15]};
            end
            out_ch.ready <= stall_pat[15];
        end
    end

    // result checker
    always @(posedge i_clk) begin
        vit_pkg::t_out_item want;
        vit_pkg::t_out_item got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, actual %p", $time, got);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (got.handled !== want.handled) begin
                    $display("%0t: handled mismatch, expected %0b actual %0b",
                             $time, want.handled, got.handled);
                    fail_count++;
                end
                if (got.read_data !== want.read_data) begin
                    $display("%0t: read_data mismatch, expected %02h actual %02h",
                             $time, want.read_data, got.read_data);
                    fail_count++;
                end
                if (got.pass_through !== want.pass_through) begin
                    $display("%0t: pass_through mismatch, expected %0b actual %0b",
                             $time, want.pass_through, got.pass_through);
                    fail_count++;
                end
                if (got.irq_divisor !== want.irq_divisor) begin
                    $display("%0t: irq_divisor mismatch, expected %0d actual %0d",
                             $time, want.irq_divisor, got.irq_divisor);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        vit_pkg::t_in_item          item;
        vit_pkg::t_cfg_word         base_list [NUM_PHASES];
        logic [vit_pkg::TICK_W-1:0] tick_cur;
        int                         lane;

        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = vit_pkg::BASE_RESET;

        base_cfg = vit_pkg::BASE_RESET;
        for (int k = 0; k < vit_pkg::NUM_COUNTERS; k++) begin
            cnt_mode[k]    = vit_pkg::MODE_RESET;
            rw_mode[k]     = vit_pkg::BM_BOTH;
            reload_val[k]  = vit_pkg::RELOAD_RESET;
            wr_msb_next[k] = 1'b0;
            rd_msb_next[k] = 1'b0;
            latch_flag[k]  = 1'b0;
            latch_val[k]   = '0;
            load_tick[k]   = '0;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed accesses under the reset base reload
        for (int r = 0; r < NUM_ROWS; r++) begin
            item.op         = SCRIPT[r].op;
            item.port       = SCRIPT[r].port;
            item.write_data = SCRIPT[r].wdata;
            item.tick_now   = SCRIPT[r].tick;
            send_access(item, SCRIPT[r].typed, SCRIPT[r].want);
        end

        // zero base reload is treated as one by the block
        base_list[0] = 16'd1;
        base_list[1] = 16'hFFFF;
        base_list[2] = 16'd0;
        base_list[3] = 16'($urandom_range(1, 65535));
        base_list[4] = 16'($urandom_range(1, 4096));

        tick_cur = $urandom;
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle(SETTLE_CYC);
            write_base(base_list[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                lane = $urandom_range(0, 8);
                item.port = (lane == 8) ? vit_pkg::PORT_W'($urandom) : TIMER_PORTS[lane];
                if (item.port == vit_pkg::PORT_CMD_LO || item.port == vit_pkg::PORT_CMD_HI)
                    item.op = ($urandom_range(0, 9) != 0) ? OP_WR : OP_RD;
                else
                    item.op = $urandom_range(0, 1) ? OP_WR : OP_RD;
                item.write_data = vit_pkg::BYTE_W'($urandom);
                tick_cur = tick_cur + $urandom_range(0, 40);
                if ($urandom_range(0, 31) == 0) tick_cur = $urandom;
                item.tick_now = tick_cur;
                send_access(item, 1'b0, NO_EXP);
            end
        end

        settle(120);
        $display("%0d port accesses sent, %0d results checked", n_sent, n_checked);
        $display("%0d base reload settings applied after the reset value", n_settings);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
sv/vit_pkg.sv
sv/vit_chan_if.sv
sv/vit_div.sv
sv/virtual_interval_timer_ports.sv
dv/testbench.sv
